// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the pixel writer checks.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define OBPW_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("obpw check failed");

// next-cycle implication
`define OBPW_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("obpw check failed");

`endif

// ===== hw/rtl/obpw_pkg.sv =====
// ----------------------------------------------------------------------------
// Pixel writer package
// Types, codes and constants shared by the bit-plane pixel writer modules.
// ----------------------------------------------------------------------------
package obpw_pkg;

	localparam int FRAME_BYTES_DEF = 8192;
	localparam int COORD_BITS_DEF  = 10;
	localparam int SIZE_W          = 10;
	localparam int BPR_W           = SIZE_W - 3;
	localparam int PAGE_W          = 18;
	localparam int QDEPTH          = 4;
	localparam int QPTR_W          = $clog2(QDEPTH);
	localparam int QCNT_W          = $clog2(QDEPTH + 1);
	localparam int CFG_IDX_W       = 3;

	localparam logic [CFG_IDX_W-1:0] REG_ORIENTATION  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_WIDE    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_NARROW  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_INVERT       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SPLIT_HALVES = 3'd4;

	localparam logic [SIZE_W-1:0] RESET_WIDE   = 10'd296;
	localparam logic [SIZE_W-1:0] RESET_NARROW = 10'd152;

	localparam logic [1:0] ROT_0   = 2'd0;
	localparam logic [1:0] ROT_90  = 2'd1;
	localparam logic [1:0] ROT_180 = 2'd2;
	localparam logic [1:0] ROT_270 = 2'd3;

	localparam logic [1:0] COL_WHITE = 2'd0;
	localparam logic [1:0] COL_BLACK = 2'd1;
	localparam logic [1:0] COL_GREY  = 2'd2;

	localparam logic FUNC_PLOT  = 1'b0;
	localparam logic FUNC_CLEAR = 1'b1;

	localparam logic STATUS_DONE  = 1'b0;
	localparam logic STATUS_RANGE = 1'b1;

	localparam logic [7:0] FILL_ZEROS = 8'h00;
	localparam logic [7:0] FILL_ONES  = 8'hFF;
	localparam logic [7:0] FILL_EVEN  = 8'h55;
	localparam logic [7:0] FILL_ODD   = 8'hAA;

	typedef enum logic [2:0] {
		OP_NOP,
		OP_SET,
		OP_CLR,
		OP_FILL,
		OP_FILL_GREY
	} op_t;

	typedef enum logic [1:0] {
		ACT_NONE,
		ACT_SET,
		ACT_CLR
	} act_t;

	typedef enum logic [1:0] {
		BK_INIT,
		BK_IDLE,
		BK_RMW,
		BK_FILL
	} bk_state_t;

	typedef struct packed {
		op_t               op;
		logic              status;
		logic [PAGE_W-1:0] addr;
		logic [2:0]        bitsel;
		logic [7:0]        fill;
	} entry_t;

	typedef struct packed {
		logic [1:0]        orientation;
		logic [SIZE_W-1:0] size_wide;
		logic [SIZE_W-1:0] size_narrow;
		logic              invert;
		logic              split_halves;
	} cfg_t;

endpackage

// ===== hw/rtl/obpw_fifo.sv =====
// ----------------------------------------------------------------------------
// Command queue
// Short queue of classified commands between the front and the back end.
// ----------------------------------------------------------------------------
module obpw_fifo (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	input  obpw_pkg::entry_t            push_data,
	input  logic                        pop,
	output obpw_pkg::entry_t            head,
	output logic                        empty,
	output logic [obpw_pkg::QCNT_W-1:0] count
);

	logic [obpw_pkg::QPTR_W-1:0] wr_q;
	logic [obpw_pkg::QPTR_W-1:0] rd_q;
	logic [obpw_pkg::QCNT_W-1:0] cnt_q;
	obpw_pkg::entry_t            slot_q [obpw_pkg::QDEPTH];

	localparam logic [obpw_pkg::QPTR_W-1:0] PTR_LAST = obpw_pkg::QPTR_W'(obpw_pkg::QDEPTH - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_LAST) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_LAST) ? '0 : rd_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_data;
		end
	end

	assign head  = slot_q[rd_q];
	assign empty = (cnt_q == '0);
	assign count = cnt_q;

endmodule

// ===== hw/rtl/obpw_front.sv =====
// ----------------------------------------------------------------------------
// Front end
// Accepts commands, checks and maps coordinates, forms byte address and action.
// ----------------------------------------------------------------------------
module obpw_front #(
	parameter int COORD_BITS  = obpw_pkg::COORD_BITS_DEF,
	parameter int FRAME_BYTES = obpw_pkg::FRAME_BYTES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic                        func,
	input  logic [COORD_BITS-1:0]       coord_x,
	input  logic [COORD_BITS-1:0]       coord_y,
	input  logic [1:0]                  colour,
	input  obpw_pkg::cfg_t              cfg,
	input  logic [obpw_pkg::PAGE_W-1:0] page,
	input  logic [obpw_pkg::QCNT_W-1:0] q_count,
	input  logic                        init_busy,
	output logic                        push,
	output obpw_pkg::entry_t            push_data
);

	localparam int SW    = obpw_pkg::SIZE_W;
	localparam int CMP_W = (COORD_BITS > SW) ? COORD_BITS : SW;
	localparam int OCC_W = obpw_pkg::QCNT_W + 1;
	localparam int PRD_W = SW + obpw_pkg::BPR_W;

	logic                  v_s1;
	logic                  func_s1;
	logic [COORD_BITS-1:0] x_s1;
	logic [COORD_BITS-1:0] y_s1;
	logic [1:0]            colour_s1;

	logic                  v_s2;
	logic                  func_s2;
	logic                  oob_s2;
	logic [SW-1:0]         row_s2;
	logic [SW-1:0]         col_s2;
	logic                  upper_s2;
	obpw_pkg::act_t        act_s2;
	logic [1:0]            colour_s2;

	logic [OCC_W-1:0]      occ;
	logic                  accept;
	logic [CMP_W-1:0]      x_e, y_e, wide_e, narr_e;
	logic                  x_lt_w, x_lt_n, y_lt_w, y_lt_n;
	logic [SW-1:0]         x_sz, y_sz;
	logic                  oob;
	logic [SW-1:0]         row, col, col_adj, half_n;
	logic                  upper;
	logic [1:0]            colour_eff;
	obpw_pkg::act_t        act;

	logic [obpw_pkg::BPR_W-1:0]  bpr, stride;
	logic [PRD_W-1:0]            prod;
	logic [obpw_pkg::PAGE_W-1:0] addr;
	logic                        in_store;

	assign occ    = OCC_W'(q_count) + OCC_W'(v_s1) + OCC_W'(v_s2);
	assign busy   = init_busy || (occ >= OCC_W'(obpw_pkg::QDEPTH));
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_s1   <= func;
			x_s1      <= coord_x;
			y_s1      <= coord_y;
			colour_s1 <= colour;
		end
		func_s2   <= func_s1;
		oob_s2    <= oob;
		row_s2    <= row;
		col_s2    <= col_adj;
		upper_s2  <= upper;
		act_s2    <= act;
		colour_s2 <= colour_s1;
	end

	assign x_e    = CMP_W'(x_s1);
	assign y_e    = CMP_W'(y_s1);
	assign wide_e = CMP_W'(cfg.size_wide);
	assign narr_e = CMP_W'(cfg.size_narrow);
	assign x_lt_w = x_e < wide_e;
	assign x_lt_n = x_e < narr_e;
	assign y_lt_w = y_e < wide_e;
	assign y_lt_n = y_e < narr_e;
	assign x_sz   = SW'(x_e);
	assign y_sz   = SW'(y_e);
	assign half_n = cfg.size_narrow >> 1;

	always_comb begin
		unique case (cfg.orientation)
			obpw_pkg::ROT_90: begin
				oob = !(x_lt_w && y_lt_n);
				row = x_sz;
				col = cfg.size_narrow - SW'(1) - y_sz;
			end
			obpw_pkg::ROT_180: begin
				oob = !(x_lt_n && y_lt_w);
				row = cfg.size_wide - SW'(1) - y_sz;
				col = cfg.size_narrow - SW'(1) - x_sz;
			end
			obpw_pkg::ROT_270: begin
				oob = !(x_lt_w && y_lt_n);
				row = cfg.size_wide - SW'(1) - x_sz;
				col = y_sz;
			end
			default: begin
				oob = !(x_lt_n && y_lt_w);
				row = y_sz;
				col = x_sz;
			end
		endcase

		if (colour_s1 == obpw_pkg::COL_GREY) begin
			colour_eff = (row[0] ^ col[0]) ? obpw_pkg::COL_WHITE : obpw_pkg::COL_BLACK;
		end else begin
			colour_eff = colour_s1;
		end

		if ((colour_eff == obpw_pkg::COL_WHITE) != cfg.invert) begin
			act = obpw_pkg::ACT_CLR;
		end else if ((colour_eff == obpw_pkg::COL_BLACK) != cfg.invert) begin
			act = obpw_pkg::ACT_SET;
		end else begin
			act = obpw_pkg::ACT_NONE;
		end

		upper   = cfg.split_halves && (col >= half_n);
		col_adj = upper ? col - half_n : col;
	end

	assign bpr    = cfg.size_narrow[SW-1:3];
	assign stride = cfg.split_halves ? (bpr >> 1) : bpr;
	assign prod   = row_s2 * stride;
	assign addr   = obpw_pkg::PAGE_W'(prod)
	              + obpw_pkg::PAGE_W'(col_s2[SW-1:3])
	              + (upper_s2 ? (page >> 1) : '0);
	assign in_store = addr < obpw_pkg::PAGE_W'(FRAME_BYTES);

	always_comb begin
		push_data.op     = obpw_pkg::OP_NOP;
		push_data.status = obpw_pkg::STATUS_DONE;
		push_data.addr   = addr;
		push_data.bitsel = col_s2[2:0];
		push_data.fill   = obpw_pkg::FILL_ONES;
		if (func_s2 == obpw_pkg::FUNC_CLEAR) begin
			push_data.op = (colour_s2 == obpw_pkg::COL_GREY) ?
			               obpw_pkg::OP_FILL_GREY : obpw_pkg::OP_FILL;
			if ((colour_s2 == obpw_pkg::COL_WHITE) != cfg.invert) begin
				push_data.fill = obpw_pkg::FILL_ZEROS;
			end
		end else if (oob_s2) begin
			push_data.status = obpw_pkg::STATUS_RANGE;
		end else if (in_store) begin
			unique case (act_s2)
				obpw_pkg::ACT_SET: push_data.op = obpw_pkg::OP_SET;
				obpw_pkg::ACT_CLR: push_data.op = obpw_pkg::OP_CLR;
				default:           push_data.op = obpw_pkg::OP_NOP;
			endcase
		end
	end

	assign push = v_s2;

endmodule

// ===== hw/rtl/obpw_back.sv =====
// ----------------------------------------------------------------------------
// Back end
// Owns the frame store: reset sweep, byte read-modify-write and page fill.
// ----------------------------------------------------------------------------
module obpw_back #(
	parameter  int FRAME_BYTES = obpw_pkg::FRAME_BYTES_DEF,
	localparam int ADDR_W      = $clog2(FRAME_BYTES),
	localparam int CNT_W       = ADDR_W + 1
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       q_empty,
	input  obpw_pkg::entry_t           q_head,
	output logic                       q_pop,
	input  logic [obpw_pkg::BPR_W-1:0] bpr,
	input  logic [CNT_W-1:0]           clip,
	output logic                       init_busy,
	output logic                       done,
	output logic                       status
);

	localparam logic [CNT_W-1:0] SWEEP_LAST = CNT_W'(FRAME_BYTES - 1);

	obpw_pkg::bk_state_t        state_q, state_d;
	logic [CNT_W-1:0]           cnt_q, cnt_d;
	logic [obpw_pkg::BPR_W-1:0] j_q, j_d;
	logic                       par_q, par_d;
	logic                       done_q, done_d;
	logic                       status_q, status_d;
	logic                       load;
	obpw_pkg::entry_t           cur_q;

	logic [7:0]        mem [FRAME_BYTES];
	logic [7:0]        rd_data_q;
	logic [ADDR_W-1:0] rd_addr;
	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	logic [7:0]        wr_data;
	logic [7:0]        mask;

	assign rd_addr = q_head.addr[ADDR_W-1:0];
	assign mask    = 8'h80 >> cur_q.bitsel;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cur_q <= q_head;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= obpw_pkg::BK_INIT;
			cnt_q    <= '0;
			j_q      <= '0;
			par_q    <= 1'b0;
			done_q   <= 1'b0;
			status_q <= obpw_pkg::STATUS_DONE;
		end else begin
			state_q  <= state_d;
			cnt_q    <= cnt_d;
			j_q      <= j_d;
			par_q    <= par_d;
			done_q   <= done_d;
			status_q <= status_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		j_d      = j_q;
		par_d    = par_q;
		done_d   = 1'b0;
		status_d = obpw_pkg::STATUS_DONE;
		q_pop    = 1'b0;
		load     = 1'b0;
		wr_en    = 1'b0;
		wr_addr  = cnt_q[ADDR_W-1:0];
		wr_data  = obpw_pkg::FILL_ZEROS;

		unique case (state_q)
			obpw_pkg::BK_INIT: begin
				wr_en = 1'b1;
				if (cnt_q == SWEEP_LAST) begin
					cnt_d   = '0;
					state_d = obpw_pkg::BK_IDLE;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			obpw_pkg::BK_IDLE: begin
				if (!q_empty) begin
					q_pop = 1'b1;
					load  = 1'b1;
					unique case (q_head.op) inside
						obpw_pkg::OP_SET, obpw_pkg::OP_CLR: begin
							state_d = obpw_pkg::BK_RMW;
						end
						obpw_pkg::OP_FILL, obpw_pkg::OP_FILL_GREY: begin
							cnt_d   = '0;
							j_d     = '0;
							par_d   = 1'b0;
							state_d = obpw_pkg::BK_FILL;
						end
						default: begin
							done_d   = 1'b1;
							status_d = q_head.status;
						end
					endcase
				end
			end
			obpw_pkg::BK_RMW: begin
				wr_en    = 1'b1;
				wr_addr  = cur_q.addr[ADDR_W-1:0];
				wr_data  = (cur_q.op == obpw_pkg::OP_SET) ?
				           (rd_data_q | mask) : (rd_data_q & ~mask);
				done_d   = 1'b1;
				status_d = cur_q.status;
				state_d  = obpw_pkg::BK_IDLE;
			end
			obpw_pkg::BK_FILL: begin
				if (cnt_q == clip) begin
					cnt_d   = '0;
					done_d  = 1'b1;
					state_d = obpw_pkg::BK_IDLE;
				end else begin
					wr_en = 1'b1;
					if (cur_q.op == obpw_pkg::OP_FILL_GREY) begin
						wr_data = par_q ? obpw_pkg::FILL_ODD : obpw_pkg::FILL_EVEN;
					end else begin
						wr_data = cur_q.fill;
					end
					cnt_d = cnt_q + 1'b1;
					if (j_q == bpr - obpw_pkg::BPR_W'(1)) begin
						j_d   = '0;
						par_d = !par_q;
					end else begin
						j_d = j_q + 1'b1;
					end
				end
			end
			default: begin
				state_d = obpw_pkg::BK_IDLE;
			end
		endcase
	end

	assign init_busy = (state_q == obpw_pkg::BK_INIT);
	assign done      = done_q;
	assign status    = status_q;

endmodule

// ===== hw/rtl/oriented_bitplane_pixel_writer.sv =====
// ----------------------------------------------------------------------------
// Oriented bit-plane pixel writer
// 1-bit-per-pixel frame store writer with rotation, dither and page clear.
// Command channel: an item is taken on a clock edge with start high and busy
// low. Each item gives one beat on done/status, in order, one cycle wide; the
// receiver cannot stall it. Registers are written through cfg_valid/cfg_ready
// (always ready) with cfg_index and cfg_data; the user must write them only
// while the block is idle, which the block itself does not enforce. A plot
// passes the front stages s1 and s2 and the command queue; the back end then
// pops it, reads its byte, writes it back and strobes done. An out-of-range or
// no-op plot is answered at the pop without touching the store. A clear writes
// min(page, FRAME_BYTES) bytes, one byte written per cycle. Up to QDEPTH items
// are buffered ahead of the store, so start may be given while earlier items
// are still being written. After reset the store is swept to zero, busy high.
module oriented_bitplane_pixel_writer #(
	parameter int FRAME_BYTES = obpw_pkg::FRAME_BYTES_DEF,
	parameter int COORD_BITS  = obpw_pkg::COORD_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic                           func,
	input  logic [COORD_BITS-1:0]          coord_x,
	input  logic [COORD_BITS-1:0]          coord_y,
	input  logic [1:0]                     colour,
	output logic                           done,
	output logic                           status,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [obpw_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [obpw_pkg::SIZE_W-1:0]    cfg_data
);

	localparam int ADDR_W = $clog2(FRAME_BYTES);
	localparam int CNT_W  = ADDR_W + 1;

	obpw_pkg::cfg_t              cfg_q;
	logic [obpw_pkg::PAGE_W-1:0] page_q;
	logic [obpw_pkg::BPR_W-1:0]  bpr;
	logic [CNT_W-1:0]            clip;
	logic                        cfg_wr;

	logic                        q_push;
	obpw_pkg::entry_t            q_push_data;
	logic                        q_pop;
	obpw_pkg::entry_t            q_head;
	logic                        q_empty;
	logic [obpw_pkg::QCNT_W-1:0] q_count;
	logic                        init_busy;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.orientation  <= obpw_pkg::ROT_0;
			cfg_q.size_wide    <= obpw_pkg::RESET_WIDE;
			cfg_q.size_narrow  <= obpw_pkg::RESET_NARROW;
			cfg_q.invert       <= 1'b0;
			cfg_q.split_halves <= 1'b0;
		end else if (cfg_wr) begin
			unique case (cfg_index)
				obpw_pkg::REG_ORIENTATION:  cfg_q.orientation  <= cfg_data[1:0];
				obpw_pkg::REG_SIZE_WIDE:    cfg_q.size_wide    <= cfg_data;
				obpw_pkg::REG_SIZE_NARROW:  cfg_q.size_narrow  <= cfg_data;
				obpw_pkg::REG_INVERT:       cfg_q.invert       <= cfg_data[0];
				obpw_pkg::REG_SPLIT_HALVES: cfg_q.split_halves <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	assign bpr = cfg_q.size_narrow[obpw_pkg::SIZE_W-1:3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_q <= '0;
		end else begin
			page_q <= obpw_pkg::PAGE_W'(cfg_q.size_wide) * obpw_pkg::PAGE_W'(bpr);
		end
	end

	assign clip = (page_q >= obpw_pkg::PAGE_W'(FRAME_BYTES)) ?
	              CNT_W'(FRAME_BYTES) : CNT_W'(page_q);

	obpw_front #(
		.COORD_BITS  (COORD_BITS),
		.FRAME_BYTES (FRAME_BYTES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.func      (func),
		.coord_x   (coord_x),
		.coord_y   (coord_y),
		.colour    (colour),
		.cfg       (cfg_q),
		.page      (page_q),
		.q_count   (q_count),
		.init_busy (init_busy),
		.push      (q_push),
		.push_data (q_push_data)
	);

	obpw_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_push_data),
		.pop       (q_pop),
		.head      (q_head),
		.empty     (q_empty),
		.count     (q_count)
	);

	obpw_back #(
		.FRAME_BYTES (FRAME_BYTES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.bpr       (bpr),
		.clip      (clip),
		.init_busy (init_busy),
		.done      (done),
		.status    (status)
	);

endmodule

// ===== hw/rtl/obpw_checker.sv =====
// ----------------------------------------------------------------------------
// Pixel writer port checker
// Tracks owed result beats on the top-level ports and checks their bounds.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module obpw_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done
);

	localparam int OWED_W = $clog2(obpw_pkg::QDEPTH + 3);
	localparam logic [OWED_W-1:0] OWED_MAX = OWED_W'(obpw_pkg::QDEPTH + 2);

	logic              accept;
	logic [OWED_W-1:0] owed_q;

	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owed_q <= '0;
		end else begin
			case ({accept, done})
				2'b10:   owed_q <= owed_q + 1'b1;
				2'b01:   owed_q <= owed_q - 1'b1;
				default: owed_q <= owed_q;
			endcase
		end
	end

	`OBPW_ASSERT_IMP(a_done_owed, clk, arst_n, done, owed_q != '0)
	`OBPW_ASSERT_IMP(a_owed_bound, clk, arst_n, 1'b1, owed_q <= OWED_MAX)
	`OBPW_ASSERT_IMP(a_full_busy, clk, arst_n, owed_q == OWED_MAX, busy)
	`OBPW_ASSERT_NXT(a_accept_owed, clk, arst_n, accept, owed_q != '0)

endmodule

bind oriented_bitplane_pixel_writer obpw_checker u_checker (.*);

// ===== tb/sv/oriented_bitplane_pixel_writer_tb.sv =====
// ----------------------------------------------------------------------------
// Oriented bit-plane pixel writer testbench
// Feeds plot and clear commands through the start/busy channel and checks
// the status beat of each one against a range predictor. The predictor keeps
// its own copy of the panel registers, which are rewritten between phases
// once the block has gone quiet. A directed opening covers the four
// orientations, all colours, the panel edges, the smallest and largest
// panels, a narrow size that is not a multiple of eight and addresses past
// the store. Randomised phases with bursty issue follow.
// ----------------------------------------------------------------------------
module oriented_bitplane_pixel_writer_tb;
	import obpw_pkg::*;

	localparam int COORD_W   = COORD_BITS_DEF;
	localparam int QUIET_MIN = 8;
	localparam logic [1:0] COL_OTHER = 2'd3;

	typedef enum logic [1:0] {
		CMD_ITEM,
		CMD_REG,
		CMD_DRAIN
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t            kind;
		logic                 func;
		logic [COORD_W-1:0]   x;
		logic [COORD_W-1:0]   y;
		logic [1:0]           colour;
		logic [CFG_IDX_W-1:0] idx;
		logic [SIZE_W-1:0]    data;
	} cmd_t;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 start     = 1'b0;
	logic                 func      = FUNC_PLOT;
	logic [COORD_W-1:0]   coord_x   = '0;
	logic [COORD_W-1:0]   coord_y   = '0;
	logic [1:0]           colour    = COL_WHITE;
	logic                 cfg_valid = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_ORIENTATION;
	logic [SIZE_W-1:0]    cfg_data  = '0;
	logic                 busy;
	logic                 done;
	logic                 status;
	logic                 cfg_ready;

	cmd_t cmd_q[$];
	logic status_due[$];

	int sent_count = 0;
	int got_count  = 0;
	int err_count  = 0;
	int burst_left = 1;
	int gap_left   = 0;
	int quiet      = 0;
	int cycles     = 0;
	int cycle_limit = 2000000000;
	int budget     = 0;
	int n_plots    = 0;
	int n_rejects  = 0;
	int n_clears   = 0;
	int n_regs     = 0;
	int n_drains   = 0;

	// predictor copy of the panel registers
	logic [1:0]        mdl_orient = ROT_0;
	logic [SIZE_W-1:0] mdl_wide   = RESET_WIDE;
	logic [SIZE_W-1:0] mdl_narrow = RESET_NARROW;
	logic              mdl_invert = 1'b0;
	logic              mdl_split  = 1'b0;

	// generator copy, used to aim coordinates and size the run limit
	logic [1:0] gen_orient = ROT_0;
	int         gen_wide   = RESET_WIDE;
	int         gen_narrow = RESET_NARROW;

	oriented_bitplane_pixel_writer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.func      (func),
		.coord_x   (coord_x),
		.coord_y   (coord_y),
		.colour    (colour),
		.done      (done),
		.status    (status),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic logic range_status(logic f, logic [COORD_W-1:0] x,
			logic [COORD_W-1:0] y);
		int lim_x;
		int lim_y;
		if (f == FUNC_CLEAR) return STATUS_DONE;
		if (mdl_orient == ROT_90 || mdl_orient == ROT_270) begin
			lim_x = int'(mdl_wide);
			lim_y = int'(mdl_narrow);
		end else begin
			lim_x = int'(mdl_narrow);
			lim_y = int'(mdl_wide);
		end
		return (int'(x) < lim_x && int'(y) < lim_y) ? STATUS_DONE : STATUS_RANGE;
	endfunction

	task automatic report_mismatch(input string what);
		$display("[%0d] mismatch: %s", cycles, what);
		err_count++;
	endtask

	task automatic add_plot(input int x, input int y, input int c);
		cmd_t cmd;
		cmd = '0;
		cmd.kind   = CMD_ITEM;
		cmd.func   = FUNC_PLOT;
		cmd.x      = COORD_W'(x);
		cmd.y      = COORD_W'(y);
		cmd.colour = 2'(c);
		cmd_q.push_back(cmd);
		budget += 45;
	endtask

	task automatic add_clear(input int c);
		cmd_t cmd;
		int   page;
		cmd = '0;
		cmd.kind   = CMD_ITEM;
		cmd.func   = FUNC_CLEAR;
		cmd.x      = COORD_W'($urandom_range(0, 1023));
		cmd.y      = COORD_W'($urandom_range(0, 1023));
		cmd.colour = 2'(c);
		cmd_q.push_back(cmd);
		page = gen_wide * (gen_narrow >> 3);
		budget += ((page < FRAME_BYTES_DEF) ? page : FRAME_BYTES_DEF) + 45;
	endtask

	task automatic add_reg(input logic [CFG_IDX_W-1:0] idx, input int data);
		cmd_t cmd;
		cmd = '0;
		cmd.kind = CMD_REG;
		cmd.idx  = idx;
		cmd.data = SIZE_W'(data);
		cmd_q.push_back(cmd);
		case (idx)
			REG_ORIENTATION: gen_orient = 2'(data);
			REG_SIZE_WIDE:   gen_wide   = data;
			REG_SIZE_NARROW: gen_narrow = data;
			default: ;
		endcase
		budget += 40;
	endtask

	task automatic add_drain();
		cmd_t cmd;
		cmd = '0;
		cmd.kind = CMD_DRAIN;
		cmd_q.push_back(cmd);
		budget += 40;
	endtask

	// driver: command issue and register writes
	always @(posedge clk) begin
		logic took_item;
		logic took_reg;
		logic waiting;
		logic nx_start;
		logic nx_valid;
		if (arst_n) begin
			took_item = start && !busy;
			took_reg  = cfg_valid && cfg_ready;
			nx_start  = 1'b0;
			nx_valid  = 1'b0;
			if (took_item) begin
				status_due.push_back(range_status(func, coord_x, coord_y));
				if (func == FUNC_CLEAR) begin
					n_clears++;
				end else begin
					n_plots++;
					if (range_status(func, coord_x, coord_y) == STATUS_RANGE) n_rejects++;
				end
				sent_count <= sent_count + 1;
				void'(cmd_q.pop_front());
				if (burst_left > 0) burst_left--;
				if (burst_left == 0) begin
					gap_left = ($urandom_range(0, 3) == 0) ? 0 :
						($urandom_range(0, 1) ? $urandom_range(1, 4) : $urandom_range(5, 30));
					burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80) :
						$urandom_range(1, 24);
				end
			end
			if (took_reg) begin
				case (cfg_index)
					REG_ORIENTATION:  mdl_orient = cfg_data[1:0];
					REG_SIZE_WIDE:    mdl_wide   = cfg_data;
					REG_SIZE_NARROW:  mdl_narrow = cfg_data;
					REG_INVERT:       mdl_invert = cfg_data[0];
					REG_SPLIT_HALVES: mdl_split  = cfg_data[0];
					default: ;
				endcase
				n_regs++;
				void'(cmd_q.pop_front());
			end
			waiting = took_item || (sent_count != got_count);
			if (waiting || start) quiet = 0;
			else if (quiet < 1000) quiet++;

			if (start && !took_item) begin
				nx_start = 1'b1;
			end else if (cfg_valid && !took_reg) begin
				nx_valid = 1'b1;
			end else if (cmd_q.size() != 0) begin
				case (cmd_q[0].kind)
					CMD_ITEM: begin
						if (gap_left == 0) begin
							nx_start = 1'b1;
							func    <= cmd_q[0].func;
							coord_x <= cmd_q[0].x;
							coord_y <= cmd_q[0].y;
							colour  <= cmd_q[0].colour;
						end else begin
							gap_left--;
						end
					end
					CMD_REG: begin
						if (!waiting && quiet >= QUIET_MIN && !busy) begin
							nx_valid = 1'b1;
							cfg_index <= cmd_q[0].idx;
							cfg_data  <= cmd_q[0].data;
						end
					end
					default: begin
						if (!waiting) begin
							void'(cmd_q.pop_front());
							n_drains++;
						end
					end
				endcase
			end
			start     <= nx_start;
			cfg_valid <= nx_valid;
		end
	end

	// monitor: status beats against the predicted order
	always @(posedge clk) begin
		logic want;
		if (arst_n && done) begin
			if (got_count == sent_count) begin
				report_mismatch($sformatf("result beat with nothing outstanding, status %0b",
					status));
			end else begin
				want = status_due.pop_front();
				if (status !== want)
					report_mismatch($sformatf("command %0d: status %0b, predicted %0b",
						got_count, status, want));
				got_count <= got_count + 1;
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > cycle_limit) begin
			$display("run limit of %0d cycles reached, %0d commands pending, %0d outstanding",
				cycle_limit, cmd_q.size(), sent_count - got_count);
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		int ph;
		int k;
		int w;
		int n;
		int sel;
		int lx;
		int ly;
		int x;
		int y;
		int r;

		// reset panel: 296 x 152, orientation 0
		add_plot(0, 0, COL_WHITE);
		add_plot(0, 0, COL_BLACK);
		add_plot(5, 6, COL_GREY);
		add_plot(7, 7, COL_OTHER);
		add_plot(151, 295, COL_BLACK);
		add_plot(152, 0, COL_BLACK);
		add_plot(0, 296, COL_WHITE);
		add_plot(1023, 1023, COL_GREY);
		add_clear(COL_WHITE);
		add_clear(COL_GREY);
		add_drain();

		add_reg(REG_ORIENTATION, ROT_90);
		add_reg(REG_INVERT, 1);
		add_reg(REG_SPLIT_HALVES, 1);
		add_plot(295, 151, COL_OTHER);
		add_plot(296, 0, COL_WHITE);
		add_plot(0, 152, COL_GREY);
		add_plot(100, 100, COL_GREY);
		add_clear(COL_BLACK);

		// smallest panel
		add_reg(REG_ORIENTATION, ROT_180);
		add_reg(REG_SIZE_WIDE, 1);
		add_reg(REG_SIZE_NARROW, 8);
		add_reg(REG_INVERT, 0);
		add_reg(REG_SPLIT_HALVES, 0);
		add_plot(7, 0, COL_BLACK);
		add_plot(8, 0, COL_BLACK);
		add_plot(0, 1, COL_WHITE);
		add_clear(COL_GREY);

		// largest panel, most of it past the store
		add_reg(REG_ORIENTATION, ROT_270);
		add_reg(REG_SIZE_WIDE, 1023);
		add_reg(REG_SIZE_NARROW, 1016);
		add_reg(REG_SPLIT_HALVES, 1);
		add_plot(1022, 1015, COL_BLACK);
		add_plot(1023, 0, COL_BLACK);
		add_clear(COL_OTHER);

		// narrow size off the byte grid
		add_reg(REG_ORIENTATION, ROT_0);
		add_reg(REG_SIZE_WIDE, 5);
		add_reg(REG_SIZE_NARROW, 13);
		add_reg(REG_SPLIT_HALVES, 0);
		add_plot(12, 4, COL_BLACK);
		add_plot(13, 4, COL_GREY);

		for (ph = 0; ph < 10; ph++) begin
			sel = $urandom_range(0, 9);
			if (sel == 0) begin
				w = 1023;
				n = 1016;
			end else if (sel == 1) begin
				w = 1;
				n = 8;
			end else begin
				w = $urandom_range(1, 80);
				n = (sel == 2) ? $urandom_range(8, 90) : 8 * $urandom_range(1, 12);
			end
			add_reg(REG_ORIENTATION, (ph < 4) ? ph : $urandom_range(0, 3));
			add_reg(REG_SIZE_WIDE, w);
			add_reg(REG_SIZE_NARROW, n);
			add_reg(REG_INVERT, $urandom_range(0, 1));
			add_reg(REG_SPLIT_HALVES, $urandom_range(0, 1));
			lx = (gen_orient == ROT_90 || gen_orient == ROT_270) ? gen_wide : gen_narrow;
			ly = (gen_orient == ROT_90 || gen_orient == ROT_270) ? gen_narrow : gen_wide;
			for (k = 0; k < 183; k++) begin
				r = $urandom_range(0, 99);
				if (r < 2) begin
					add_clear($urandom_range(0, 3));
				end else begin
					if (r < 75) begin
						x = $urandom_range(0, lx - 1);
						y = $urandom_range(0, ly - 1);
					end else if (r < 88) begin
						if ($urandom_range(0, 1)) begin
							x = lx - 1 + $urandom_range(0, 2);
							y = $urandom_range(0, ly + 1);
						end else begin
							x = $urandom_range(0, lx + 1);
							y = ly - 1 + $urandom_range(0, 2);
						end
					end else begin
						x = $urandom_range(0, 1023);
						y = $urandom_range(0, 1023);
					end
					add_plot((x > 1023) ? 1023 : x, (y > 1023) ? 1023 : y, $urandom_range(0, 3));
				end
				if (k == 90 && ph % 3 == 0) add_drain();
			end
		end
		cycle_limit = 3 * (budget + FRAME_BYTES_DEF) + 20000;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		@(negedge clk);
		while (cmd_q.size() != 0 || sent_count != got_count) @(negedge clk);
		repeat (20) @(negedge clk);
		if (status_due.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", status_due.size()));

		$display("covered %0d plots (%0d out of range) and %0d clears over %0d register writes",
			n_plots, n_rejects, n_clears, n_regs);
		$display("with %0d full drains and %0d mismatches", n_drains, err_count);
		if (err_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
